// File: sv/osbt_pkg.sv
// ============================================================================
// osbt_pkg
// Shared widths, codes and types of the object start boundary table.
// ============================================================================
package osbt_pkg;

    localparam int OPCODE_W    = 1;
    localparam int START_W     = 17;
    localparam int END_W       = 18;
    localparam int CARD_W      = 11;
    localparam int NEXT_W      = 12;
    localparam int FIRST_W     = 17;
    localparam int CODE_W      = 8;
    localparam int EXP_W       = CODE_W - 1;
    localparam int DIST_MAX    = 127;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    // classified request handed from the front end to the back end
    typedef struct packed {
        logic              is_query;
        logic [CARD_W-1:0] card;
        logic              card_ok;
        logic [END_W-1:0]  obj_end;
        logic [CODE_W-1:0] first_code;
    } t_cmd;

    typedef struct packed {
        logic [NEXT_W-1:0]  next_card_index;
        logic [FIRST_W-1:0] first_object_start;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_WALK,
        ST_PUSH
    } t_state;

    // back-jump code -(e+1) in two's complement
    function automatic logic [CODE_W-1:0] jump_code(input logic [EXP_W-1:0] e);
        return ~{1'b0, e};
    endfunction

endpackage

// File: sv/osbt_if.sv
// ============================================================================
// osbt_req_if / osbt_rsp_if
// Valid/ready channels carrying table requests and their results.
// ============================================================================
interface osbt_req_if import osbt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [START_W-1:0]  object_start;
    logic [END_W-1:0]    object_end;
    logic [CARD_W-1:0]   card_index;

    modport source (output valid, output opcode, output object_start,
                    output object_end, output card_index, input ready);
    modport sink   (input valid, input opcode, input object_start,
                    input object_end, input card_index, output ready);
endinterface

interface osbt_rsp_if import osbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NEXT_W-1:0]  next_card_index;
    logic [FIRST_W-1:0] first_object_start;

    modport source (output valid, output next_card_index,
                    output first_object_start, input ready);
    modport sink   (input valid, input next_card_index,
                    input first_object_start, output ready);
endinterface

// File: sv/object_start_boundary_table.sv
// ============================================================================
// object_start_boundary_table
// Per-card object start table for a collected heap segment.
// ============================================================================
// Usage:
//   i_req carries requests (valid/ready). opcode OP_RECORD stores the first
//   boundary distance at card_index and back-jump codes in every further card
//   boundary inside [object_start, object_end); opcode OP_QUERY walks the
//   codes back from card_index. o_rsp carries one result per request, in
//   order: next_card_index for a record, first_object_start for a query.
//   A record writes the first code and then one back-jump code per further
//   card; a query reads one code per back jump followed, and a card beyond
//   the table answers zero without a read. The code memory has one port:
//   one write or one read per cycle. A two-entry request queue lets i_req
//   keep accepting while the back end works or while a result waits in the
//   output register; when o_rsp stalls, the back end holds its result and
//   the queue fills, then ready drops. Reset empties the queue and the
//   output register; the code memory is not cleared, and a query must only
//   reach cards written since reset.
// ============================================================================
module object_start_boundary_table import osbt_pkg::*; #(
    parameter int NUM_CARDS      = 2048,
    parameter int LOG_CARD_WORDS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    osbt_req_if.sink   i_req,
    osbt_rsp_if.source o_rsp
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    osbt_front #(
        .NUM_CARDS      (NUM_CARDS),
        .LOG_CARD_WORDS (LOG_CARD_WORDS)
    ) u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    osbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    osbt_back #(
        .NUM_CARDS      (NUM_CARDS),
        .LOG_CARD_WORDS (LOG_CARD_WORDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: sv/osbt_front.sv
// ============================================================================
// osbt_front
// Accepts requests and classifies them; computes the first boundary code.
// ============================================================================
module osbt_front import osbt_pkg::*; #(
    parameter int NUM_CARDS      = 2048,
    parameter int LOG_CARD_WORDS = 6
) (
    osbt_req_if.sink   i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [END_W-1:0]  bnd;
    logic [END_W-1:0]  start;
    logic [END_W-1:0]  gap;
    logic [CODE_W-1:0] first_dist;

    always_comb begin
        bnd   = END_W'(i_req.card_index) << LOG_CARD_WORDS;
        start = END_W'(i_req.object_start);
        gap   = bnd - start;
        // start past the boundary stores zero; long gaps saturate
        if (bnd < start) begin
            first_dist = '0;
        end else if (gap > END_W'(DIST_MAX)) begin
            first_dist = CODE_W'(DIST_MAX);
        end else begin
            first_dist = gap[CODE_W-1:0];
        end
    end

    assign o_cmd.is_query   = (i_req.opcode == OP_QUERY);
    assign o_cmd.card       = i_req.card_index;
    assign o_cmd.card_ok    = (32'(i_req.card_index) < NUM_CARDS);
    assign o_cmd.obj_end    = i_req.object_end;
    assign o_cmd.first_code = first_dist;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

// File: sv/osbt_queue.sv
// ============================================================================
// osbt_queue
// Short request queue between the front end and the back end.
// ============================================================================
module osbt_queue import osbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CNW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNW'(1);
                2'b01:   r_count <= r_count - CNW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == CNW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// File: sv/osbt_back.sv
// ============================================================================
// osbt_back
// Executes requests against the code memory: boundary fill and back-walk.
// ============================================================================
module osbt_back import osbt_pkg::*; #(
    parameter int NUM_CARDS      = 2048,
    parameter int LOG_CARD_WORDS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    osbt_rsp_if.source o_rsp
);

    localparam int IW = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
    localparam int CW = (IW + 1 > NEXT_W) ? IW + 1 : NEXT_W;
    localparam int EW = (CW + LOG_CARD_WORDS > END_W) ? CW + LOG_CARD_WORDS : END_W;
    localparam int DW = (IW + LOG_CARD_WORDS > FIRST_W) ? IW + LOG_CARD_WORDS : FIRST_W;

    logic [CODE_W-1:0] r_mem [NUM_CARDS];
    logic [CODE_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [END_W-1:0]  r_end, n_end;
    logic [EXP_W-1:0]  r_exp, n_exp;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_run, n_run;
    logic [IW-1:0]     r_walk, n_walk;
    t_rsp              r_res, n_res;
    logic              r_out_valid;
    t_rsp              r_out;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              out_load;
    logic              fill_go;
    logic [EXP_W-1:0]  hop_exp;
    logic [IW-1:0]     step;
    logic [DW-1:0]     bnd;
    logic [DW-1:0]     diff;

    // single-port code memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx  <= n_idx;
        r_end  <= n_end;
        r_exp  <= n_exp;
        r_used <= n_used;
        r_run  <= n_run;
        r_walk <= n_walk;
        r_res  <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_end    = r_end;
        n_exp    = r_exp;
        n_used   = r_used;
        n_run    = r_run;
        n_walk   = r_walk;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        o_pop    = 1'b0;
        out_load = 1'b0;
        fill_go  = (r_idx < CW'(NUM_CARDS))
                && ((EW'(r_idx) << LOG_CARD_WORDS) < EW'(r_end));
        hop_exp  = ~r_rd_data[EXP_W-1:0];
        step     = IW'(1) << hop_exp;
        bnd      = DW'(r_walk) << LOG_CARD_WORDS;
        diff     = bnd - DW'(r_rd_data);

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_query) begin
                        if (i_cmd.card_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = IW'(i_cmd.card);
                            n_walk  = IW'(i_cmd.card);
                            n_state = ST_WALK;
                        end else begin
                            n_res   = '0;
                            n_state = ST_PUSH;
                        end
                    end else begin
                        wr_en   = i_cmd.card_ok;
                        wr_addr = IW'(i_cmd.card);
                        wr_data = i_cmd.first_code;
                        n_idx   = CW'(i_cmd.card) + CW'(1);
                        n_end   = i_cmd.obj_end;
                        n_exp   = '0;
                        n_used  = '0;
                        n_run   = CW'(1);
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (fill_go) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx[IW-1:0];
                    wr_data = jump_code(r_exp);
                    n_idx   = r_idx + CW'(1);
                    // each exponent covers twice as many cards as the last
                    if (r_used + CW'(1) == r_run) begin
                        n_used = '0;
                        n_exp  = r_exp + EXP_W'(1);
                        n_run  = r_run << 1;
                    end else begin
                        n_used = r_used + CW'(1);
                    end
                end else begin
                    n_res.next_card_index    = r_idx[NEXT_W-1:0];
                    n_res.first_object_start = '0;
                    n_state                  = ST_PUSH;
                end
            end
            ST_WALK: begin
                if (r_rd_data[CODE_W-1]) begin
                    // jump past card zero ends the walk with zero
                    if (int'(hop_exp) >= IW || step > r_walk) begin
                        n_res   = '0;
                        n_state = ST_PUSH;
                    end else begin
                        n_walk  = r_walk - step;
                        rd_en   = 1'b1;
                        rd_addr = r_walk - step;
                    end
                end else begin
                    n_res.next_card_index = '0;
                    if (DW'(r_rd_data) > bnd) begin
                        n_res.first_object_start = '0;
                    end else begin
                        n_res.first_object_start = diff[FIRST_W-1:0];
                    end
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.next_card_index    = r_out.next_card_index;
    assign o_rsp.first_object_start = r_out.first_object_start;

endmodule

// File: sv/osbt_checker.sv
// ============================================================================
// osbt_checker
// Port-level checks of the object start boundary table.
// ============================================================================
module osbt_checker import osbt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    osbt_req_if.sink   i_req,
    osbt_rsp_if.source o_rsp
);

    localparam int MAX_OPEN = QUEUE_DEPTH + 2;

    logic       req_fire;
    logic       rsp_fire;
    logic [2:0] r_open;

    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_fire = o_rsp.valid && o_rsp.ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 3'(req_fire) - 3'(rsp_fire);
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid
            && $stable(o_rsp.next_card_index) && $stable(o_rsp.first_object_start))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_fire |-> r_open != 3'd0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_open) <= MAX_OPEN)
        else $error("more requests in flight than the block can hold");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> 32'(r_open) >= QUEUE_DEPTH)
        else $error("ready low with the queue not full");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.next_card_index == '0 || o_rsp.first_object_start == '0)
        else $error("result carries both record and query fields");

endmodule

bind object_start_boundary_table osbt_checker u_osbt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
